[rtl/core/hts_pkg.sv]
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, codes and reset values of the heightfield triangle sampler.
// ----------------------------------------------------------------------------
package hts_pkg;

	localparam int POS_W     = 32;
	localparam int PROD_FRAC = 32;
	localparam int INV_W     = 24;
	localparam int RES_W     = 7;
	localparam int OUT_W     = 16;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int LIDX_W    = 12;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [INV_W-1:0]        inv_t;
	typedef logic [RES_W-1:0]        res_t;
	typedef logic signed [OUT_W-1:0] hgt_t;
	typedef logic [CFG_W-1:0]        cfg_data_t;
	typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
	typedef logic [LIDX_W-1:0]       lidx_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X       = 3'd0,
		REG_ORIGIN_Z       = 3'd1,
		REG_INV_SPACING    = 3'd2,
		REG_RES_X          = 3'd3,
		REG_RES_Z          = 3'd4,
		REG_INVALID_HEIGHT = 3'd5
	} cfg_reg_t;

	localparam inv_t INV_RESET     = 24'h01_0000;
	localparam res_t RES_RESET     = 7'd64;
	localparam hgt_t INVALID_RESET = 16'sh8000;

endpackage

[rtl/core/heightfield_triangle_sampler.sv]
// ----------------------------------------------------------------------------
// heightfield_triangle_sampler
// Loads grid heights into a row-major store and answers height samples by
// barycentric interpolation over the triangle of the cell under a position.
// Throughput: one request per cycle, busy never rises.
// done rises once an accepted request has passed every pipeline stage and the output register.
// Four store copies give the four corner reads of a sample in the same cycle.
// Reset clears configuration to defaults and empties the pipeline; the
// store holds no defined value until loaded, no clearing pass.
// ----------------------------------------------------------------------------
module heightfield_triangle_sampler #(
	parameter int MAX_RES     = 64,
	parameter int FRAC_BITS   = 16,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 operation,
	input  hts_pkg::pos_t        pos_x,
	input  hts_pkg::pos_t        pos_z,
	input  hts_pkg::lidx_t       load_index,
	input  hts_pkg::hgt_t        load_height,
	output logic                 done,
	output hts_pkg::hgt_t        height,
	output logic                 valid_res,
	input  logic                 cfg_we,
	input  hts_pkg::cfg_idx_t    cfg_index,
	input  hts_pkg::cfg_data_t   cfg_wdata
);

	import hts_pkg::*;

	localparam int IW    = $clog2(MAX_RES);
	localparam int RW    = $clog2(MAX_RES + 1);
	localparam int CW    = IW + FRAC_BITS;
	localparam int DEPTH = MAX_RES * MAX_RES;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = FRAC_BITS + 1;
	localparam int PRW   = FRAC_BITS + HEIGHT_BITS + 2;
	localparam int SUMW  = FRAC_BITS + HEIGHT_BITS + 18;
	localparam logic [WW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// configuration
	pos_t origin_x_q;
	pos_t origin_z_q;
	inv_t inv_spacing_q;
	res_t res_x_q;
	res_t res_z_q;
	hgt_t invalid_height_q;
	logic [RW-1:0] rx_sat;
	logic [RW-1:0] rz_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q       <= '0;
			origin_z_q       <= '0;
			inv_spacing_q    <= INV_RESET;
			res_x_q          <= RES_RESET;
			res_z_q          <= RES_RESET;
			invalid_height_q <= INVALID_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X:       origin_x_q       <= cfg_wdata;
				REG_ORIGIN_Z:       origin_z_q       <= cfg_wdata;
				REG_INV_SPACING:    inv_spacing_q    <= cfg_wdata[INV_W-1:0];
				REG_RES_X:          res_x_q          <= cfg_wdata[RES_W-1:0];
				REG_RES_Z:          res_z_q          <= cfg_wdata[RES_W-1:0];
				REG_INVALID_HEIGHT: invalid_height_q <= cfg_wdata[OUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (res_x_q < RES_W'(2)) begin
			rx_sat = RW'(2);
		end else if (int'(res_x_q) > MAX_RES) begin
			rx_sat = RW'(MAX_RES);
		end else begin
			rx_sat = RW'(res_x_q);
		end
		if (res_z_q < RES_W'(2)) begin
			rz_sat = RW'(2);
		end else if (int'(res_z_q) > MAX_RES) begin
			rz_sat = RW'(MAX_RES);
		end else begin
			rz_sat = RW'(res_z_q);
		end
	end

	// request acceptance
	logic go;

	assign busy = 1'b0;
	assign go   = start && !busy;

	// stages 1 to 3: grid mapping
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	op_t  op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;
	lidx_t lidx_s1, lidx_s2, lidx_s3, lidx_s4;
	logic signed [HEIGHT_BITS-1:0] lh_s1, lh_s2, lh_s3, lh_s4;

	logic          inside_x_s3;
	logic          inside_z_s3;
	logic [CW-1:0] coord_x_s3;
	logic [CW-1:0] coord_z_s3;

	hts_axis #(
		.MAX_RES   (MAX_RES),
		.FRAC_BITS (FRAC_BITS)
	) u_axis_x (
		.clk         (clk),
		.pos         (pos_x),
		.origin      (origin_x_q),
		.inv_spacing (inv_spacing_q),
		.res         (rx_sat),
		.inside_s3   (inside_x_s3),
		.coord_s3    (coord_x_s3)
	);

	hts_axis #(
		.MAX_RES   (MAX_RES),
		.FRAC_BITS (FRAC_BITS)
	) u_axis_z (
		.clk         (clk),
		.pos         (pos_z),
		.origin      (origin_z_q),
		.inv_spacing (inv_spacing_q),
		.res         (rz_sat),
		.inside_s3   (inside_z_s3),
		.coord_s3    (coord_z_s3)
	);

	// stage 3 to 4: corner addresses and weights
	logic [IW-1:0]        ci;
	logic [IW-1:0]        cj;
	logic [FRAC_BITS-1:0] fx;
	logic [FRAC_BITS-1:0] fz;
	logic                 lower_w;
	logic [AW-1:0]        base;
	logic [AW-1:0]        row_up;
	logic [WW-1:0]        wa_w;
	logic [WW-1:0]        wb_w;
	logic [WW-1:0]        wc_w;

	always_comb begin
		ci      = coord_x_s3[CW-1:FRAC_BITS];
		cj      = coord_z_s3[CW-1:FRAC_BITS];
		fx      = coord_x_s3[FRAC_BITS-1:0];
		fz      = coord_z_s3[FRAC_BITS-1:0];
		lower_w = (fz <= fx);
		base    = AW'(AW'(cj) * AW'(rx_sat)) + AW'(ci);
		row_up  = base + AW'(rx_sat);
		if (lower_w) begin
			wa_w = ONE - WW'(fx);
			wb_w = WW'(fx - fz);
			wc_w = WW'(fz);
		end else begin
			wa_w = ONE - WW'(fz);
			wb_w = WW'(fz - fx);
			wc_w = WW'(fx);
		end
	end

	logic [AW-1:0] a00_s4, a10_s4, a01_s4, a11_s4;
	logic [WW-1:0] wa_s4, wb_s4, wc_s4;
	logic          lower_s4, inside_s4;

	// stage 4 to 5: store access, loads write here in request order
	logic [WW-1:0] wa_s5, wb_s5, wc_s5;
	logic          lower_s5, inside_s5;
	logic          st_we;
	logic [HEIGHT_BITS-1:0] q00, q10, q01, q11;

	assign st_we = vld_s4 && (op_s4 == OP_LOAD) && (int'(lidx_s4) < DEPTH);

	hts_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(DEPTH)) u_ram_00 (
		.clk (clk), .we (st_we), .waddr (AW'(lidx_s4)), .wdata (lh_s4),
		.raddr (a00_s4), .rdata (q00)
	);

	hts_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(DEPTH)) u_ram_10 (
		.clk (clk), .we (st_we), .waddr (AW'(lidx_s4)), .wdata (lh_s4),
		.raddr (a10_s4), .rdata (q10)
	);

	hts_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(DEPTH)) u_ram_01 (
		.clk (clk), .we (st_we), .waddr (AW'(lidx_s4)), .wdata (lh_s4),
		.raddr (a01_s4), .rdata (q01)
	);

	hts_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(DEPTH)) u_ram_11 (
		.clk (clk), .we (st_we), .waddr (AW'(lidx_s4)), .wdata (lh_s4),
		.raddr (a11_s4), .rdata (q11)
	);

	// stage 5 to 6: weight products
	logic signed [HEIGHT_BITS-1:0] hb_w;
	logic signed [PRW-1:0]         pa_s6, pb_s6, pc_s6;
	logic                          inside_s6;

	assign hb_w = lower_s5 ? $signed(q10) : $signed(q01);

	// stage 6 to output: sum and round half up
	logic signed [SUMW-1:0] sum_w;
	hgt_t height_q;
	logic valid_res_q;
	logic done_q;

	assign sum_w = SUMW'(pa_s6) + SUMW'(pb_s6) + SUMW'(pc_s6)
		+ (SUMW'(1) <<< (FRAC_BITS - 1));

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= go;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			done_q <= vld_s6;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		op_s1   <= op_t'(operation);
		lidx_s1 <= load_index;
		lh_s1   <= HEIGHT_BITS'(load_height);

		op_s2   <= op_s1;
		lidx_s2 <= lidx_s1;
		lh_s2   <= lh_s1;

		op_s3   <= op_s2;
		lidx_s3 <= lidx_s2;
		lh_s3   <= lh_s2;

		op_s4     <= op_s3;
		lidx_s4   <= lidx_s3;
		lh_s4     <= lh_s3;
		a00_s4    <= base;
		a10_s4    <= base + AW'(1);
		a01_s4    <= row_up;
		a11_s4    <= row_up + AW'(1);
		wa_s4     <= wa_w;
		wb_s4     <= wb_w;
		wc_s4     <= wc_w;
		lower_s4  <= lower_w;
		inside_s4 <= inside_x_s3 && inside_z_s3;

		op_s5     <= op_s4;
		wa_s5     <= wa_s4;
		wb_s5     <= wb_s4;
		wc_s5     <= wc_s4;
		lower_s5  <= lower_s4;
		inside_s5 <= inside_s4;

		op_s6     <= op_s5;
		inside_s6 <= inside_s5;
		pa_s6     <= $signed({1'b0, wa_s5}) * $signed(q00);
		pb_s6     <= $signed({1'b0, wb_s5}) * hb_w;
		pc_s6     <= $signed({1'b0, wc_s5}) * $signed(q11);

		if (op_s6 == OP_LOAD) begin
			height_q    <= '0;
			valid_res_q <= 1'b0;
		end else if (!inside_s6) begin
			height_q    <= invalid_height_q;
			valid_res_q <= 1'b0;
		end else begin
			height_q    <= sum_w[FRAC_BITS +: OUT_W];
			valid_res_q <= 1'b1;
		end
	end

	assign done      = done_q;
	assign height    = height_q;
	assign valid_res = valid_res_q;

endmodule

[rtl/core/hts_ram.sv]
// ----------------------------------------------------------------------------
// hts_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/hts_axis.sv]
// ----------------------------------------------------------------------------
// hts_axis
// One axis of the position to grid mapping: offset, scale, range check and
// clamp below the last vertex, over three register stages.
// ----------------------------------------------------------------------------
module hts_axis #(
	parameter int MAX_RES   = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  hts_pkg::pos_t                         pos,
	input  hts_pkg::pos_t                         origin,
	input  hts_pkg::inv_t                         inv_spacing,
	input  logic [$clog2(MAX_RES+1)-1:0]          res,
	output logic                                  inside_s3,
	output logic [$clog2(MAX_RES)+FRAC_BITS-1:0]  coord_s3
);

	import hts_pkg::*;

	localparam int IW = $clog2(MAX_RES);
	localparam int RW = $clog2(MAX_RES + 1);
	localparam int CW = IW + FRAC_BITS;
	localparam int DW = POS_W + 1;
	localparam int PW = DW + INV_W + 1;
	localparam int SH = PROD_FRAC - FRAC_BITS;

	logic signed [DW-1:0] diff_s1;
	logic signed [PW-1:0] prod_s2;
	logic [RW-1:0]        res_m1;
	logic [PW-1:0]        lim;
	logic [CW-1:0]        top;
	logic                 in_w;
	logic                 at_top;

	always_comb begin
		res_m1 = res - RW'(1);
		lim    = PW'(res_m1) << PROD_FRAC;
		top    = (CW'(res_m1) << FRAC_BITS) - CW'(1);
		in_w   = !prod_s2[PW-1] && ($unsigned(prod_s2) <= lim);
		at_top = ($unsigned(prod_s2) == lim);
	end

	always_ff @(posedge clk) begin
		diff_s1   <= DW'(pos) - DW'(origin);
		prod_s2   <= diff_s1 * $signed({1'b0, inv_spacing});
		inside_s3 <= in_w;
		coord_s3  <= at_top ? top : prod_s2[SH +: CW];
	end

endmodule
